// ===== rtl/c65_pkg.sv =====
// Shared types, constants and decode functions for the 6502 execute unit.
package c65_pkg;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] operand_low;
      logic [7:0] operand_high;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic [7:0]  x_out;
      logic [7:0]  y_out;
      logic [7:0]  sp_out;
      logic [7:0]  status_out;
      logic [15:0] next_pc;
      logic        bad_opcode;
   } rsp_type;

   typedef enum logic [5:0] {
      OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_STA, OP_LDA, OP_CMP, OP_SBC,
      OP_BIT, OP_STY, OP_LDY, OP_CPY, OP_CPX,
      OP_ASL, OP_ROL, OP_LSR, OP_ROR, OP_STX, OP_LDX, OP_DEC, OP_INC,
      OP_BRK, OP_JSR, OP_RTI, OP_RTS, OP_JMP, OP_JMPI, OP_PHP, OP_PLP, OP_PHA, OP_PLA,
      OP_DEY, OP_TAY, OP_INY, OP_INX, OP_DEX, OP_TYA, OP_TXA, OP_TXS, OP_TAX, OP_TSX,
      OP_FLAG, OP_NOP, OP_BRANCH, OP_BAD
   } op_type;

   typedef enum logic [3:0] {
      M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_INX, M_INY, M_REL
   } mode_type;

   typedef struct packed {
      op_type   op;
      mode_type mode;
   } decode_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ADDR, S_OPER, S_EXEC, S_PUSH, S_PULL, S_PULL_TAKE,
      S_PAIR_A, S_PAIR_B, S_PAIR_C, S_FIN
   } state_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
      logic [7:0] r;
      logic       taken;
   } alu_res_type;

   localparam logic [7:0] F_C = 8'h01;
   localparam logic [7:0] F_Z = 8'h02;
   localparam logic [7:0] F_I = 8'h04;
   localparam logic [7:0] F_D = 8'h08;
   localparam logic [7:0] F_V = 8'h40;
   localparam logic [7:0] F_N = 8'h80;
   localparam logic [7:0] F_PUSHED = 8'h30;
   localparam logic [7:0] F_PULL_MASK = 8'hCF;
   localparam logic [7:0] NZ_KEEP = 8'h7D;
   localparam logic [7:0] STACK_PAGE = 8'h01;
   localparam logic [15:0] BRK_VECTOR = 16'hFFFE;

   localparam op_type OP_CC1 [8] = '{OP_ORA, OP_AND, OP_EOR, OP_ADC,
                                     OP_STA, OP_LDA, OP_CMP, OP_SBC};
   localparam op_type OP_CC0 [8] = '{OP_BAD, OP_BIT, OP_BAD, OP_BAD,
                                     OP_STY, OP_LDY, OP_CPY, OP_CPX};
   localparam op_type OP_CC2 [8] = '{OP_ASL, OP_ROL, OP_LSR, OP_ROR,
                                     OP_STX, OP_LDX, OP_DEC, OP_INC};
   localparam logic [7:0] OK_CC0 [8] = '{8'h00, 8'h0A, 8'h00, 8'h00,
                                         8'h2A, 8'hAB, 8'h0B, 8'h0B};
   localparam logic [7:0] OK_CC2 [8] = '{8'hAA, 8'hAA, 8'hAA, 8'hAA,
                                         8'h2A, 8'hAB, 8'hAA, 8'hAA};
   localparam mode_type MODE_CC1 [8] = '{M_INX, M_ZP, M_IMM, M_ABS,
                                         M_INY, M_ZPX, M_ABY, M_ABX};
   localparam mode_type MODE_CC02 [8] = '{M_IMM, M_ZP, M_IMP, M_ABS,
                                          M_IMP, M_ZPX, M_IMP, M_ABX};

   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      return (p & NZ_KEEP) | ((v == 8'h00) ? F_Z : 8'h00) | (v & F_N);
   endfunction

   function automatic logic [1:0] mode_len(input mode_type m);
      logic [1:0] n;
      unique case (m)
         M_IMP, M_ACC: n = 2'd1;
         M_ABS, M_ABX, M_ABY: n = 2'd3;
         default: n = 2'd2;
      endcase
      return n;
   endfunction

   function automatic decode_type decode(input logic [7:0] opc);
      decode_type d;
      logic [2:0] aaa;
      logic [2:0] bbb;
      logic [7:0] ok;
      aaa = opc[7:5];
      bbb = opc[4:2];
      d.op = OP_BAD;
      d.mode = M_IMP;
      ok = 8'h00;
      unique case (opc)
         8'h00: d.op = OP_BRK;
         8'h20: begin
            d.op = OP_JSR;
            d.mode = M_ABS;
         end
         8'h40: d.op = OP_RTI;
         8'h60: d.op = OP_RTS;
         8'h4C: begin
            d.op = OP_JMP;
            d.mode = M_ABS;
         end
         8'h6C: begin
            d.op = OP_JMPI;
            d.mode = M_ABS;
         end
         8'h08: d.op = OP_PHP;
         8'h28: d.op = OP_PLP;
         8'h48: d.op = OP_PHA;
         8'h68: d.op = OP_PLA;
         8'h88: d.op = OP_DEY;
         8'hA8: d.op = OP_TAY;
         8'hC8: d.op = OP_INY;
         8'hE8: d.op = OP_INX;
         8'hCA: d.op = OP_DEX;
         8'h98: d.op = OP_TYA;
         8'h8A: d.op = OP_TXA;
         8'h9A: d.op = OP_TXS;
         8'hAA: d.op = OP_TAX;
         8'hBA: d.op = OP_TSX;
         8'hEA: d.op = OP_NOP;
         8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8: d.op = OP_FLAG;
         8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
            d.op = OP_CC2[aaa];
            d.mode = M_ACC;
         end
         default: begin
            if (opc[4:0] == 5'h10) begin
               d.op = OP_BRANCH;
               d.mode = M_REL;
            end else if (opc[1:0] == 2'b01) begin
               if (opc != 8'h89) begin
                  d.op = OP_CC1[aaa];
                  d.mode = MODE_CC1[bbb];
               end
            end else if (opc[1:0] != 2'b11) begin
               ok = (opc[1:0] == 2'b00) ? OK_CC0[aaa] : OK_CC2[aaa];
               if (ok[bbb]) begin
                  d.op = (opc[1:0] == 2'b00) ? OP_CC0[aaa] : OP_CC2[aaa];
                  d.mode = MODE_CC02[bbb];
                  if (d.op == OP_LDX || d.op == OP_STX) begin
                     if (d.mode == M_ZPX) d.mode = M_ZPY;
                     if (d.mode == M_ABX) d.mode = M_ABY;
                  end
               end
            end
         end
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/c65_alu.sv =====
// Shared arithmetic, logic, shift and register-transfer unit of the execute unit.
module c65_alu (
   input  c65_pkg::op_type      op,
   input  logic [7:0]           opc,
   input  logic [7:0]           v,
   input  logic                 acc_mode,
   input  logic [7:0]           a,
   input  logic [7:0]           x,
   input  logic [7:0]           y,
   input  logic [7:0]           sp,
   input  logic [7:0]           p,
   output c65_pkg::alu_res_type res
);

   logic [7:0] bv;
   logic [8:0] sum;
   logic       ovf;
   logic [4:0] al;
   logic [9:0] ar;
   logic [5:0] sl;
   logic [9:0] sr;
   logic [7:0] cmp_reg;
   logic [7:0] sh;
   logic       sh_c;
   logic [7:0] sel;
   logic [7:0] add_res;
   logic       add_c;
   logic       sub;

   always_comb begin
      sub = (op == c65_pkg::OP_SBC);
      bv = sub ? ~v : v;
      sum = {1'b0, a} + {1'b0, bv} + {8'h00, p[0]};
      ovf = (~(a ^ bv) & (a ^ sum[7:0]) & c65_pkg::F_N) != 8'h00;

      al = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, p[0]};
      if (al >= 5'd10) al = {1'b0, 4'(al[3:0] + 4'd6)} + 5'h10;
      ar = {2'b00, a[7:4], 4'h0} + {2'b00, v[7:4], 4'h0} + {5'h00, al};
      if (ar >= 10'h0A0) ar = ar + 10'h060;

      sl = {2'b00, a[3:0]} - {2'b00, v[3:0]} + {5'h00, p[0]} - 6'd1;
      if (sl[5]) sl = {2'b00, 4'(sl[3:0] + 4'd10)} - 6'd16;
      sr = {2'b00, a[7:4], 4'h0} - {2'b00, v[7:4], 4'h0} + {{4{sl[5]}}, sl};
      if (sr[9]) sr = sr - 10'h060;

      add_res = sum[7:0];
      add_c = sum[8];
      if ((p & c65_pkg::F_D) != 8'h00) begin
         if (sub) begin
            add_res = sr[7:0];
         end else begin
            add_res = ar[7:0];
            add_c = ar >= 10'h100;
         end
      end

      sh = v;
      sh_c = p[0];
      case (op)
         c65_pkg::OP_ASL: {sh_c, sh} = {v, 1'b0};
         c65_pkg::OP_ROL: {sh_c, sh} = {v, p[0]};
         c65_pkg::OP_LSR: {sh, sh_c} = {1'b0, v};
         c65_pkg::OP_ROR: {sh, sh_c} = {p[0], v};
         c65_pkg::OP_INC: sh = v + 8'd1;
         c65_pkg::OP_DEC: sh = v - 8'd1;
         default: sh = v;
      endcase

      cmp_reg = (op == c65_pkg::OP_CPX) ? x : ((op == c65_pkg::OP_CPY) ? y : a);

      case (opc[7:6])
         2'd0: sel = c65_pkg::F_N;
         2'd1: sel = c65_pkg::F_V;
         2'd2: sel = c65_pkg::F_C;
         default: sel = c65_pkg::F_Z;
      endcase

      res.a = a;
      res.x = x;
      res.y = y;
      res.sp = sp;
      res.p = p;
      res.r = sh;
      res.taken = 1'b0;
      unique case (op)
         c65_pkg::OP_ORA: begin
            res.a = a | v;
            res.p = c65_pkg::set_nz(p, a | v);
         end
         c65_pkg::OP_AND: begin
            res.a = a & v;
            res.p = c65_pkg::set_nz(p, a & v);
         end
         c65_pkg::OP_EOR: begin
            res.a = a ^ v;
            res.p = c65_pkg::set_nz(p, a ^ v);
         end
         c65_pkg::OP_ADC, c65_pkg::OP_SBC: begin
            res.a = add_res;
            res.p = c65_pkg::set_nz({p[7], ovf, p[5:1], add_c}, add_res);
         end
         c65_pkg::OP_LDA: begin
            res.a = v;
            res.p = c65_pkg::set_nz(p, v);
         end
         c65_pkg::OP_LDX: begin
            res.x = v;
            res.p = c65_pkg::set_nz(p, v);
         end
         c65_pkg::OP_LDY: begin
            res.y = v;
            res.p = c65_pkg::set_nz(p, v);
         end
         c65_pkg::OP_CMP, c65_pkg::OP_CPX, c65_pkg::OP_CPY:
            res.p = c65_pkg::set_nz({p[7:1], cmp_reg >= v}, cmp_reg - v);
         c65_pkg::OP_BIT:
            res.p = {v[7], v[6], p[5:2], (a & v) == 8'h00, p[0]};
         c65_pkg::OP_ASL, c65_pkg::OP_ROL, c65_pkg::OP_LSR, c65_pkg::OP_ROR,
         c65_pkg::OP_INC, c65_pkg::OP_DEC: begin
            res.p = c65_pkg::set_nz({p[7:1], sh_c}, sh);
            if (acc_mode) res.a = sh;
         end
         c65_pkg::OP_DEY: begin
            res.y = y - 8'd1;
            res.p = c65_pkg::set_nz(p, y - 8'd1);
         end
         c65_pkg::OP_INY: begin
            res.y = y + 8'd1;
            res.p = c65_pkg::set_nz(p, y + 8'd1);
         end
         c65_pkg::OP_DEX: begin
            res.x = x - 8'd1;
            res.p = c65_pkg::set_nz(p, x - 8'd1);
         end
         c65_pkg::OP_INX: begin
            res.x = x + 8'd1;
            res.p = c65_pkg::set_nz(p, x + 8'd1);
         end
         c65_pkg::OP_TAY: begin
            res.y = a;
            res.p = c65_pkg::set_nz(p, a);
         end
         c65_pkg::OP_TYA: begin
            res.a = y;
            res.p = c65_pkg::set_nz(p, y);
         end
         c65_pkg::OP_TAX: begin
            res.x = a;
            res.p = c65_pkg::set_nz(p, a);
         end
         c65_pkg::OP_TXA: begin
            res.a = x;
            res.p = c65_pkg::set_nz(p, x);
         end
         c65_pkg::OP_TSX: begin
            res.x = sp;
            res.p = c65_pkg::set_nz(p, sp);
         end
         c65_pkg::OP_TXS: res.sp = x;
         c65_pkg::OP_FLAG: begin
            unique case (opc[7:5])
               3'd0: res.p = p & ~c65_pkg::F_C;
               3'd1: res.p = p | c65_pkg::F_C;
               3'd2: res.p = p & ~c65_pkg::F_I;
               3'd3: res.p = p | c65_pkg::F_I;
               3'd5: res.p = p & ~c65_pkg::F_V;
               3'd6: res.p = p & ~c65_pkg::F_D;
               default: res.p = p | c65_pkg::F_D;
            endcase
         end
         c65_pkg::OP_BRANCH: res.taken = (opc[5] == ((p & sel) != 8'h00));
         default: res.taken = 1'b0;
      endcase
   end

endmodule

// ===== rtl/cpu_6502_instruction_execute_unit.sv =====
// Top level of the 6502 execute unit: sequencer, registers and data memory.
// Each item passes address generation, then ends for an unknown opcode, writes memory for a
// store or loads the target for JMP, and runs the ALU for implied, immediate and direct memory
// work; BRK and RTI take longest, as the memory gives one registered read a cycle. A new item is
// taken only when idle and the result slot is empty or being taken. After reset the memory is
// cleared one byte a cycle, no item is accepted meanwhile, and the registers reset to A=X=Y=P=0, SP=0xFF, PC=0.
module cpu_6502_instruction_execute_unit #(
   parameter int MEM_DEPTH = 8192
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  c65_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output c65_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MEM_DEPTH);

   c65_pkg::state_type    state_ff, state_in;
   c65_pkg::req_type      req_ff, req_in;
   c65_pkg::decode_type   dec_ff, dec_in, dec_new;
   c65_pkg::rsp_type      rsp_ff, rsp_in;
   c65_pkg::alu_res_type  alu_res;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            a_ff, a_in, x_ff, x_in, y_ff, y_in;
   logic [7:0]            sp_ff, sp_in, p_ff, p_in, tmp_ff, tmp_in;
   logic [15:0]           pc_ff, pc_in, npc_ff, npc_in, addr_ff, addr_in;
   logic [1:0]            step_ff, step_in;
   logic                  bad_ff, bad_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [7:0]            mem [MEM_DEPTH];
   logic [7:0]            rd_data_ff;
   logic                  mem_we;
   logic [15:0]           mem_wa, mem_ra;
   logic [7:0]            mem_wdata;
   logic [AW-1:0]         mem_widx;
   logic                  accept;
   logic                  mem_mode;
   logic                  rmw;
   logic [1:0]            push_n, pull_n;
   logic [7:0]            push_byte;
   logic [7:0]            alu_v;
   logic [15:0]           pc2;
   logic [15:0]           word;

   function automatic logic [AW-1:0] mem_index(input logic [15:0] addr);
      logic [23:0] t;
      t = {8'h00, addr};
      for (int k = 6; k >= 0; k--) begin
         if (t >= (24'(MEM_DEPTH) << k)) t = t - (24'(MEM_DEPTH) << k);
      end
      return t[AW-1:0];
   endfunction

   assign accept = req_valid && !req_stall;
   assign req_stall = !(state_ff == c65_pkg::S_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign dec_new = c65_pkg::decode(req_data.opcode);
   assign pc2 = pc_ff + 16'd2;
   assign word = {rd_data_ff, tmp_ff};

   always_comb begin
      mem_mode = dec_ff.mode == c65_pkg::M_ZP || dec_ff.mode == c65_pkg::M_ZPX ||
                 dec_ff.mode == c65_pkg::M_ZPY || dec_ff.mode == c65_pkg::M_ABS ||
                 dec_ff.mode == c65_pkg::M_ABX || dec_ff.mode == c65_pkg::M_ABY ||
                 dec_ff.mode == c65_pkg::M_INX || dec_ff.mode == c65_pkg::M_INY;
      rmw = dec_ff.op inside {c65_pkg::OP_ASL, c65_pkg::OP_ROL, c65_pkg::OP_LSR,
                              c65_pkg::OP_ROR, c65_pkg::OP_INC, c65_pkg::OP_DEC};
      case (dec_ff.op)
         c65_pkg::OP_JSR, c65_pkg::OP_RTS: begin
            push_n = 2'd1;
            pull_n = 2'd1;
         end
         c65_pkg::OP_BRK, c65_pkg::OP_RTI: begin
            push_n = 2'd2;
            pull_n = 2'd2;
         end
         default: begin
            push_n = 2'd0;
            pull_n = 2'd0;
         end
      endcase
      case (dec_ff.op)
         c65_pkg::OP_PHA: push_byte = a_ff;
         c65_pkg::OP_PHP: push_byte = p_ff | c65_pkg::F_PUSHED;
         default: begin
            case (step_ff)
               2'd0: push_byte = pc2[15:8];
               2'd1: push_byte = pc2[7:0];
               default: push_byte = p_ff | c65_pkg::F_PUSHED;
            endcase
         end
      endcase
      if (dec_ff.mode == c65_pkg::M_IMM) alu_v = req_ff.operand_low;
      else if (mem_mode) alu_v = rd_data_ff;
      else alu_v = a_ff;
   end

   c65_alu u_alu (
      .op       (dec_ff.op),
      .opc      (req_ff.opcode),
      .v        (alu_v),
      .acc_mode (dec_ff.mode == c65_pkg::M_ACC),
      .a        (a_ff),
      .x        (x_ff),
      .y        (y_ff),
      .sp       (sp_ff),
      .p        (p_ff),
      .res      (alu_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         c65_pkg::S_CLEAR:
            if (clr_ff == AW'(MEM_DEPTH - 1)) state_in = c65_pkg::S_IDLE;
         c65_pkg::S_IDLE:
            if (accept) state_in = c65_pkg::S_ADDR;
         c65_pkg::S_ADDR: begin
            if (dec_ff.op == c65_pkg::OP_BAD) state_in = c65_pkg::S_FIN;
            else if (dec_ff.mode == c65_pkg::M_INX || dec_ff.mode == c65_pkg::M_INY)
               state_in = c65_pkg::S_PAIR_A;
            else state_in = c65_pkg::S_OPER;
         end
         c65_pkg::S_OPER: begin
            case (dec_ff.op)
               c65_pkg::OP_STA, c65_pkg::OP_STX, c65_pkg::OP_STY, c65_pkg::OP_JMP:
                  state_in = c65_pkg::S_FIN;
               c65_pkg::OP_JSR, c65_pkg::OP_BRK, c65_pkg::OP_PHA, c65_pkg::OP_PHP:
                  state_in = c65_pkg::S_PUSH;
               c65_pkg::OP_PLA, c65_pkg::OP_PLP, c65_pkg::OP_RTS, c65_pkg::OP_RTI:
                  state_in = c65_pkg::S_PULL;
               c65_pkg::OP_JMPI: state_in = c65_pkg::S_PAIR_A;
               default: state_in = c65_pkg::S_EXEC;
            endcase
         end
         c65_pkg::S_EXEC: state_in = c65_pkg::S_FIN;
         c65_pkg::S_PUSH: begin
            if (step_ff == push_n)
               state_in = (dec_ff.op == c65_pkg::OP_BRK) ? c65_pkg::S_PAIR_A : c65_pkg::S_FIN;
         end
         c65_pkg::S_PULL: state_in = c65_pkg::S_PULL_TAKE;
         c65_pkg::S_PULL_TAKE:
            state_in = (step_ff == pull_n) ? c65_pkg::S_FIN : c65_pkg::S_PULL;
         c65_pkg::S_PAIR_A: state_in = c65_pkg::S_PAIR_B;
         c65_pkg::S_PAIR_B: state_in = c65_pkg::S_PAIR_C;
         c65_pkg::S_PAIR_C: begin
            if (dec_ff.op == c65_pkg::OP_JMPI || dec_ff.op == c65_pkg::OP_BRK)
               state_in = c65_pkg::S_FIN;
            else state_in = c65_pkg::S_OPER;
         end
         c65_pkg::S_FIN: state_in = c65_pkg::S_IDLE;
         default: state_in = c65_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      dec_in = dec_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      a_in = a_ff;
      x_in = x_ff;
      y_in = y_ff;
      sp_in = sp_ff;
      p_in = p_ff;
      pc_in = pc_ff;
      npc_in = npc_ff;
      addr_in = addr_ff;
      tmp_in = tmp_ff;
      step_in = step_ff;
      bad_in = bad_ff;
      clr_in = clr_ff;
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wdata = 8'h00;
      mem_ra = addr_ff;
      unique case (state_ff)
         c65_pkg::S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
         end
         c65_pkg::S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               dec_in = dec_new;
               step_in = 2'd0;
               bad_in = dec_new.op == c65_pkg::OP_BAD;
               npc_in = (dec_new.op == c65_pkg::OP_BAD) ? pc_ff :
                        pc_ff + {14'h0000, c65_pkg::mode_len(dec_new.mode)};
            end
         end
         c65_pkg::S_ADDR: begin
            case (dec_ff.mode)
               c65_pkg::M_ZP, c65_pkg::M_INY: addr_in = {8'h00, req_ff.operand_low};
               c65_pkg::M_ZPX, c65_pkg::M_INX:
                  addr_in = {8'h00, 8'(req_ff.operand_low + x_ff)};
               c65_pkg::M_ZPY: addr_in = {8'h00, 8'(req_ff.operand_low + y_ff)};
               c65_pkg::M_ABX:
                  addr_in = {req_ff.operand_high, req_ff.operand_low} + {8'h00, x_ff};
               c65_pkg::M_ABY:
                  addr_in = {req_ff.operand_high, req_ff.operand_low} + {8'h00, y_ff};
               default: addr_in = {req_ff.operand_high, req_ff.operand_low};
            endcase
         end
         c65_pkg::S_OPER: begin
            case (dec_ff.op)
               c65_pkg::OP_STA: begin
                  mem_we = 1'b1;
                  mem_wdata = a_ff;
               end
               c65_pkg::OP_STX: begin
                  mem_we = 1'b1;
                  mem_wdata = x_ff;
               end
               c65_pkg::OP_STY: begin
                  mem_we = 1'b1;
                  mem_wdata = y_ff;
               end
               c65_pkg::OP_JMP: npc_in = addr_ff;
               default: npc_in = npc_ff;
            endcase
         end
         c65_pkg::S_EXEC: begin
            a_in = alu_res.a;
            x_in = alu_res.x;
            y_in = alu_res.y;
            sp_in = alu_res.sp;
            p_in = alu_res.p;
            if (rmw && dec_ff.mode != c65_pkg::M_ACC) begin
               mem_we = 1'b1;
               mem_wdata = alu_res.r;
            end
            if (alu_res.taken)
               npc_in = npc_ff + {{8{req_ff.operand_low[7]}}, req_ff.operand_low};
         end
         c65_pkg::S_PUSH: begin
            mem_we = 1'b1;
            mem_wa = {c65_pkg::STACK_PAGE, sp_ff};
            mem_wdata = push_byte;
            sp_in = sp_ff - 8'd1;
            step_in = step_ff + 2'd1;
            if (step_ff == push_n) begin
               step_in = 2'd0;
               if (dec_ff.op == c65_pkg::OP_JSR) npc_in = addr_ff;
               if (dec_ff.op == c65_pkg::OP_BRK) begin
                  p_in = p_ff | c65_pkg::F_I;
                  addr_in = c65_pkg::BRK_VECTOR;
               end
            end
         end
         c65_pkg::S_PULL: begin
            sp_in = sp_ff + 8'd1;
            mem_ra = {c65_pkg::STACK_PAGE, 8'(sp_ff + 8'd1)};
         end
         c65_pkg::S_PULL_TAKE: begin
            step_in = step_ff + 2'd1;
            case (dec_ff.op)
               c65_pkg::OP_PLA: begin
                  a_in = rd_data_ff;
                  p_in = c65_pkg::set_nz(p_ff, rd_data_ff);
               end
               c65_pkg::OP_PLP: p_in = rd_data_ff & c65_pkg::F_PULL_MASK;
               c65_pkg::OP_RTS: begin
                  if (step_ff == 2'd0) tmp_in = rd_data_ff;
                  else npc_in = word + 16'd1;
               end
               default: begin
                  if (step_ff == 2'd0) p_in = rd_data_ff & c65_pkg::F_PULL_MASK;
                  else if (step_ff == 2'd1) tmp_in = rd_data_ff;
                  else npc_in = word;
               end
            endcase
         end
         c65_pkg::S_PAIR_A: mem_ra = addr_ff;
         c65_pkg::S_PAIR_B: begin
            mem_ra = {addr_ff[15:8], 8'(addr_ff[7:0] + 8'd1)};
            tmp_in = rd_data_ff;
         end
         c65_pkg::S_PAIR_C: begin
            if (dec_ff.op == c65_pkg::OP_JMPI || dec_ff.op == c65_pkg::OP_BRK)
               npc_in = word;
            else if (dec_ff.mode == c65_pkg::M_INY) addr_in = word + {8'h00, y_ff};
            else addr_in = word;
         end
         c65_pkg::S_FIN: begin
            pc_in = npc_ff;
            rsp_valid_in = 1'b1;
            rsp_in.acc_out = a_ff;
            rsp_in.x_out = x_ff;
            rsp_in.y_out = y_ff;
            rsp_in.sp_out = sp_ff;
            rsp_in.status_out = p_ff;
            rsp_in.next_pc = npc_ff;
            rsp_in.bad_opcode = bad_ff;
         end
         default: clr_in = clr_ff;
      endcase
      mem_widx = (state_ff == c65_pkg::S_CLEAR) ? clr_ff : mem_index(mem_wa);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_widx] <= mem_wdata;
      rd_data_ff <= mem[mem_index(mem_ra)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c65_pkg::S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         a_ff <= 8'h00;
         x_ff <= 8'h00;
         y_ff <= 8'h00;
         sp_ff <= 8'hFF;
         p_ff <= 8'h00;
         pc_ff <= 16'h0000;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         a_ff <= a_in;
         x_ff <= x_in;
         y_ff <= y_in;
         sp_ff <= sp_in;
         p_ff <= p_in;
         pc_ff <= pc_in;
      end
      req_ff <= req_in;
      dec_ff <= dec_in;
      rsp_ff <= rsp_in;
      npc_ff <= npc_in;
      addr_ff <= addr_in;
      tmp_ff <= tmp_in;
      step_ff <= step_in;
      bad_ff <= bad_in;
   end

   a_fin_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == c65_pkg::S_FIN |-> !rsp_valid_ff)
      else $error("result completed while the output slot was occupied");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == c65_pkg::S_ADDR)
      else $error("accepted item did not start address generation");

   a_sp_only_stack: assert property (@(posedge clock) disable iff (reset)
      (state_ff != c65_pkg::S_PUSH && state_ff != c65_pkg::S_PULL &&
       state_ff != c65_pkg::S_EXEC) |=> $stable(sp_ff))
      else $error("stack pointer changed outside stack or execute work");

   a_rsp_pc_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.next_pc == pc_ff)
      else $error("pending result disagrees with the program counter");

endmodule
